FILE: rtl/core/mnp_pkg.sv
// ----------------------------------------------------------------------------
// mnp_pkg - shared definitions for the MIDI note parser / held-note set
// Event codes, register indexes, field widths and the status-byte decode.
// ----------------------------------------------------------------------------
`default_nettype none

package mnp_pkg;

    // default number of tracked keys
    localparam int KEY_COUNT_DEF = 128;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 7;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int TDATA_W  = 48;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_ON  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFF = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] NOTE_ON_RST  = 8'h90;
    localparam logic [BYTE_W-1:0] NOTE_OFF_RST = 8'h80;

    // status high nibbles
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_POLY_AT   = 4'hA;
    localparam logic [3:0] ST_CTRL      = 4'hB;
    localparam logic [3:0] ST_PROGRAM   = 4'hC;
    localparam logic [3:0] ST_CHAN_AT   = 4'hD;
    localparam logic [3:0] ST_PITCH     = 4'hE;

    // data bytes still owed by a message
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;

    // event codes of a result
    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_DEL   = 2'd1,
        KIND_OTHER = 2'd2,
        KIND_STRAY = 2'd3
    } kind_t;

    // data bytes a status byte calls for
    function automatic logic [1:0] needed_bytes(input logic [BYTE_W-1:0] status);
        logic [1:0] n;
        case (status[7:4]) inside
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_AT, ST_CTRL, ST_PITCH: n = NEED_TWO;
            ST_PROGRAM, ST_CHAN_AT:                                 n = NEED_ONE;
            default:                                                n = NEED_NONE;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/midi_note_parser_held_set_unit.sv
// ----------------------------------------------------------------------------
// midi_note_parser_held_set_unit - MIDI byte parser with a compact held-note set
// Parses running-status MIDI, tracks held notes in a swap-remove list.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per request on the s_ side; a byte can be accepted in every cycle
// unless the m_ side stalls, and the result of a byte that completes a message (or a stray
// data byte) leaves on the m_ side through the stage-1 registers and the result register.
// The decode stage decodes the byte against the running status and issues a registered
// read of the key-to-slot memory; the update stage updates the held set and the list memory,
// whose last entry is kept read ahead every cycle. Status bytes and the first of two data
// bytes give no result. The not-held state of every key lives in per-key flip-flops cleared
// by reset, so no clearing pass runs. Configuration is written through cfg_we / cfg_index /
// cfg_data by the user only while idle; the block itself does not enforce this.
`default_nettype none

module midi_note_parser_held_set_unit
    import mnp_pkg::*;
#(
    parameter int KEY_COUNT = KEY_COUNT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input byte stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata,   // [7:0] status_value, [15:8] first_data,
                                                 // [22:16] second_data, [30:23] held_count,
                                                 // [37:31] slot, [38] moved_valid,
                                                 // [45:39] moved_note, [47:46] zero
    output logic [1:0]                m_tuser,   // [1:0] event_kind
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    localparam int KI = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [BYTE_W:0]    KEY_LIMIT  = (BYTE_W + 1)'(KEY_COUNT);
    localparam logic [COUNT_W-1:0] SIZE_LIMIT = COUNT_W'(KEY_COUNT);

    // configuration registers
    logic [BYTE_W-1:0] note_on_reg, note_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_on_reg  <= NOTE_ON_RST;
            note_off_reg <= NOTE_OFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NOTE_ON:  note_on_reg  <= cfg_data;
                REG_NOTE_OFF: note_off_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic s1_valid_reg, m_valid_reg;
    logic s_accept, s1_fire;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // parse stage: running status decode
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] run_status_reg, run_status_next;
    logic [1:0]        bytes_left_reg, bytes_left_next;
    logic [DATA_W-1:0] held_first_reg, held_first_next;

    logic              p_result, p_complete;
    kind_t             p_kind;
    logic [BYTE_W-1:0] p_first;
    logic [DATA_W-1:0] p_second;
    logic [1:0]        p_need;
    logic [KI-1:0]     p_key;
    logic              p_key_ok;

    always_comb
    begin
        run_status_next = run_status_reg;
        bytes_left_next = bytes_left_reg;
        held_first_next = held_first_reg;
        p_result        = 1'b0;
        p_complete      = 1'b0;
        p_kind          = KIND_OTHER;
        p_first         = s_tdata;
        p_second        = '0;
        p_need          = needed_bytes(run_status_reg);
        if (s_tdata[7])
        begin
            run_status_next = s_tdata;
            bytes_left_next = needed_bytes(s_tdata);
        end
        else if (bytes_left_reg == NEED_NONE)
        begin
            p_result = 1'b1;
            p_kind   = KIND_STRAY;
        end
        else if (bytes_left_reg == NEED_TWO)
        begin
            held_first_next = s_tdata[DATA_W-1:0];
            bytes_left_next = NEED_ONE;
        end
        else
        begin
            p_result   = 1'b1;
            p_complete = 1'b1;
            if (p_need == NEED_TWO)
            begin
                p_first  = {1'b0, held_first_reg};
                p_second = s_tdata[DATA_W-1:0];
            end
            bytes_left_next = p_need;
        end
    end

    assign p_key    = p_first[KI-1:0];
    assign p_key_ok = ({1'b0, p_first} < KEY_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_status_reg <= '0;
            bytes_left_reg <= NEED_NONE;
            held_first_reg <= '0;
        end
        else if (s_accept)
        begin
            run_status_reg <= run_status_next;
            bytes_left_reg <= bytes_left_next;
            held_first_reg <= held_first_next;
        end
    end

    // stage-1 item registers
    kind_t             s1_kind_reg;
    logic [BYTE_W-1:0] s1_status_reg, s1_first_reg;
    logic [DATA_W-1:0] s1_second_reg;
    logic              s1_track_reg, s1_on_reg, s1_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_accept)
            s1_valid_reg <= p_result;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_kind_reg   <= p_kind;
            s1_status_reg <= run_status_reg;
            s1_first_reg  <= p_first;
            s1_second_reg <= p_second;
            s1_track_reg  <= p_complete && p_key_ok;
            s1_on_reg     <= (run_status_reg == note_on_reg);
            s1_off_reg    <= (run_status_reg == note_off_reg);
        end
    end

    // ------------------------------------------------------------------
    // held set state
    // ------------------------------------------------------------------
    logic [KEY_COUNT-1:0] held_reg;
    logic [COUNT_W-1:0]   list_size_reg, list_size_next;
    logic [KI-1:0]        slot_rd_reg;     // slot of the stage-1 key
    logic [KI-1:0]        tail_reg;        // key at the list's last entry

    // memory write requests from the update stage
    logic          slot_we, list_we;
    logic [KI-1:0] slot_waddr, slot_wdata, list_waddr, list_wdata;
    logic          held_set, held_clr;

    // update stage outputs
    kind_t             u_kind;
    logic [KI-1:0]     u_key, u_slot, u_moved_note, u_last;
    logic              u_moved;

    assign u_key  = s1_first_reg[KI-1:0];
    assign u_last = KI'(list_size_reg - COUNT_W'(1));

    always_comb
    begin
        u_kind         = s1_kind_reg;
        u_slot         = '0;
        u_moved        = 1'b0;
        u_moved_note   = '0;
        list_size_next = list_size_reg;
        slot_we        = 1'b0;
        slot_waddr     = u_key;
        slot_wdata     = '0;
        list_we        = 1'b0;
        list_waddr     = list_size_reg[KI-1:0];
        list_wdata     = u_key;
        held_set       = 1'b0;
        held_clr       = 1'b0;
        if (s1_track_reg)
        begin
            if (s1_on_reg)
            begin
                // append the key unless already held or the list is full
                if (!held_reg[u_key] && (list_size_reg < SIZE_LIMIT))
                begin
                    u_kind         = KIND_ADD;
                    u_slot         = list_size_reg[KI-1:0];
                    list_we        = 1'b1;
                    slot_we        = 1'b1;
                    slot_wdata     = list_size_reg[KI-1:0];
                    held_set       = 1'b1;
                    list_size_next = list_size_reg + COUNT_W'(1);
                end
            end
            else if (s1_off_reg)
            begin
                // remove the key, last entry fills the hole
                if (held_reg[u_key])
                begin
                    u_kind         = KIND_DEL;
                    u_slot         = slot_rd_reg;
                    held_clr       = 1'b1;
                    list_size_next = list_size_reg - COUNT_W'(1);
                    if (slot_rd_reg != u_last)
                    begin
                        u_moved      = 1'b1;
                        u_moved_note = tail_reg;
                        list_we      = 1'b1;
                        list_waddr   = slot_rd_reg;
                        list_wdata   = tail_reg;
                        slot_we      = 1'b1;
                        slot_waddr   = tail_reg;
                        slot_wdata   = slot_rd_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            list_size_reg <= '0;
        end
        else if (s1_fire)
        begin
            list_size_reg <= list_size_next;
            if (held_set)
                held_reg[u_key] <= 1'b1;
            else if (held_clr)
                held_reg[u_key] <= 1'b0;
        end
    end

    // key-to-slot memory, read at decode with write bypass
    logic [KI-1:0] slot_mem [KEY_COUNT];
    logic          slot_wr;

    assign slot_wr = s1_fire && slot_we;

    always_ff @(posedge clk)
    begin
        if (slot_wr)
            slot_mem[slot_waddr] <= slot_wdata;
        if (s_accept)
        begin
            if (slot_wr && (slot_waddr == p_key))
                slot_rd_reg <= slot_wdata;
            else
                slot_rd_reg <= slot_mem[p_key];
        end
    end

    // held list memory, last entry read ahead every cycle
    logic [KI-1:0]      list_mem [KEY_COUNT];
    logic               list_wr;
    logic [COUNT_W-1:0] size_now, tail_addr_full;
    logic [KI-1:0]      tail_addr;

    assign list_wr        = s1_fire && list_we;
    assign size_now       = s1_fire ? list_size_next : list_size_reg;
    assign tail_addr_full = size_now - COUNT_W'(1);
    assign tail_addr      = tail_addr_full[KI-1:0];

    always_ff @(posedge clk)
    begin
        if (list_wr)
            list_mem[list_waddr] <= list_wdata;
        if (list_wr && (list_waddr == tail_addr))
            tail_reg <= list_wdata;
        else
            tail_reg <= list_mem[tail_addr];
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    kind_t              o_kind_reg;
    logic [BYTE_W-1:0]  o_status_reg, o_first_reg;
    logic [DATA_W-1:0]  o_second_reg;
    logic [COUNT_W-1:0] o_count_reg;
    logic [SLOT_W-1:0]  o_slot_reg, o_moved_note_reg;
    logic               o_moved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s1_fire)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            o_kind_reg       <= u_kind;
            o_status_reg     <= s1_status_reg;
            o_first_reg      <= s1_first_reg;
            o_second_reg     <= s1_second_reg;
            o_count_reg      <= list_size_next;
            o_slot_reg       <= SLOT_W'(u_slot);
            o_moved_reg      <= u_moved;
            o_moved_note_reg <= SLOT_W'(u_moved_note);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tdata  = {2'b00, o_moved_note_reg, o_moved_reg, o_slot_reg, o_count_reg,
                       o_second_reg, o_first_reg, o_status_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // list length tracks the held flags
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(held_reg) == int'(list_size_reg))
        else $error("held flags disagree with list length");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        list_size_reg <= SIZE_LIMIT)
        else $error("held list longer than key count");

    // a move only happens on a removal
    a_move_on_del: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && o_moved_reg |-> o_kind_reg == KIND_DEL)
        else $error("moved entry reported without a removal");

    // an added note leaves the list non-empty
    a_add_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && u_kind == KIND_ADD |=> list_size_reg != '0)
        else $error("list empty after an added note");

    // a stalled update item stays put
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_first_reg))
        else $error("stalled update item lost");

endmodule

`default_nettype wire
